// ===== sv/xo256_pkg.sv =====
package xo256_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = WORD_W / 2;

  // Item function codes.
  localparam logic FUNC_NEXT = 1'b0;
  localparam logic FUNC_SEED = 1'b1;

  // Seed expansion constants.
  localparam logic [WORD_W-1:0] MIX_GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [WORD_W-1:0] MIX_MUL_1  = 64'hBF58476D1CE4E5B9;
  localparam logic [WORD_W-1:0] MIX_MUL_2  = 64'h94D049BB133111EB;
  localparam int MIX_SHIFT_0 = 30;
  localparam int MIX_SHIFT_1 = 27;
  localparam int MIX_SHIFT_2 = 31;

  // Generator constants.
  localparam int OUT_ROT   = 23;
  localparam int STATE_SHL = 17;
  localparam int STATE_ROT = 45;

  localparam int NUM_WORDS = 4;
  localparam int IDX_W     = $clog2(NUM_WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WORDS - 1);

  // Partial product phases of a 64 by 64 multiply kept modulo 2^64.
  localparam logic [1:0] MUL_PH_LL = 2'd0;
  localparam logic [1:0] MUL_PH_LH = 2'd1;
  localparam logic [1:0] MUL_PH_HL = 2'd2;

  // Selects which multiply constant of the seed mixer is in use.
  localparam logic MIX_K1 = 1'b0;
  localparam logic MIX_K2 = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRE,
    ST_MUL1,
    ST_MUL2
  } state_t;

  typedef struct packed {
    logic             load_seed;
    logic             next;
    logic             pre;
    logic             mul_en;
    logic [1:0]       mul_phase;
    logic             mul_sel;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
  } dp_cmd_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int amt);
    logic [WORD_W-1:0] r;
    r = (v << amt) | (v >> (WORD_W - amt));
    return r;
  endfunction

endpackage

// ===== sv/xo256_in_if.sv =====
interface xo256_in_if import xo256_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [WORD_W-1:0] seed_value;

  modport source (output valid, output func, output seed_value, input ready);
  modport sink (input valid, input func, input seed_value, output ready);
endinterface

// ===== sv/xo256_out_if.sv =====
interface xo256_out_if import xo256_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

// ===== sv/xo256_ctrl.sv =====
module xo256_ctrl import xo256_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_func,
  output logic    in_ready,
  input  logic    out_ready,
  output logic    out_valid,
  output dp_cmd_t cmd
);

  state_t           state_r, state_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= MUL_PH_LL;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A new transaction may enter while the output register is empty or being drained.
  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_SEED) begin
            cmd.load_seed = 1'b1;
            idx_nxt       = '0;
            state_nxt     = ST_PRE;
          end else begin
            cmd.next      = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_PRE: begin
        cmd.pre   = 1'b1;
        phase_nxt = MUL_PH_LL;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = phase_r;
        cmd.mul_sel   = MIX_K1;
        if (phase_r == MUL_PH_HL) begin
          phase_nxt = MUL_PH_LL;
          state_nxt = ST_MUL2;
        end else begin
          phase_nxt = phase_r + 2'd1;
        end
      end
      ST_MUL2: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = phase_r;
        cmd.mul_sel   = MIX_K2;
        if (phase_r == MUL_PH_HL) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_idx = idx_r;
          phase_nxt  = MUL_PH_LL;
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_PRE;
          end
        end else begin
          phase_nxt = phase_r + 2'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/xo256_dp.sv =====
module xo256_dp import xo256_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic [WORD_W-1:0] seed_value,
  output logic [WORD_W-1:0] random_word
);

  logic [WORD_W-1:0] gen_r [NUM_WORDS];
  logic [WORD_W-1:0] ctr_r, z_r, acc_r, out_word_r;

  logic [WORD_W-1:0] ctr_sum;
  logic [WORD_W-1:0] k_word;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] mul_sum, mixed;
  logic [WORD_W-1:0] out_word;
  logic [WORD_W-1:0] c1, d1, b1, a1, c2;

  assign ctr_sum = ctr_r + MIX_GOLDEN;
  assign k_word  = (cmd.mul_sel == MIX_K2) ? MIX_MUL_2 : MIX_MUL_1;

  // One 32 by 32 multiplier covers the three partial products that land below bit 64.
  always_comb begin
    mul_a = z_r[HALF_W-1:0];
    mul_b = k_word[HALF_W-1:0];
    case (cmd.mul_phase)
      MUL_PH_LL: begin
        mul_a = z_r[HALF_W-1:0];
        mul_b = k_word[HALF_W-1:0];
      end
      MUL_PH_LH: begin
        mul_a = z_r[HALF_W-1:0];
        mul_b = k_word[WORD_W-1:HALF_W];
      end
      MUL_PH_HL: begin
        mul_a = z_r[WORD_W-1:HALF_W];
        mul_b = k_word[HALF_W-1:0];
      end
      default: begin
        mul_a = z_r[HALF_W-1:0];
        mul_b = k_word[HALF_W-1:0];
      end
    endcase
  end

  assign prod    = WORD_W'(mul_a) * WORD_W'(mul_b);
  assign mul_sum = acc_r + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
  assign mixed   = (cmd.mul_sel == MIX_K2) ? (mul_sum ^ (mul_sum >> MIX_SHIFT_2))
                                           : (mul_sum ^ (mul_sum >> MIX_SHIFT_1));

  // xoshiro256++ output and state update.
  assign out_word = rotl(gen_r[0] + gen_r[3], OUT_ROT) + gen_r[0];
  assign c1 = gen_r[2] ^ gen_r[0];
  assign d1 = gen_r[3] ^ gen_r[1];
  assign b1 = gen_r[1] ^ c1;
  assign a1 = gen_r[0] ^ d1;
  assign c2 = c1 ^ (gen_r[1] << STATE_SHL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        gen_r[i] <= '0;
      end
    end else if (cmd.next) begin
      gen_r[0] <= a1;
      gen_r[1] <= b1;
      gen_r[2] <= c2;
      gen_r[3] <= rotl(d1, STATE_ROT);
    end else if (cmd.wr_en) begin
      gen_r[cmd.wr_idx] <= mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.next) begin
      out_word_r <= out_word;
    end
    if (cmd.load_seed) begin
      ctr_r <= seed_value;
    end else if (cmd.pre) begin
      ctr_r <= ctr_sum;
    end
    if (cmd.pre) begin
      z_r <= ctr_sum ^ (ctr_sum >> MIX_SHIFT_0);
    end else if (cmd.mul_en && cmd.mul_phase == MUL_PH_HL) begin
      z_r <= mixed;
    end
    if (cmd.mul_en) begin
      if (cmd.mul_phase == MUL_PH_LL) begin
        acc_r <= prod;
      end else begin
        acc_r <= mul_sum;
      end
    end
  end

  assign random_word = out_word_r;

endmodule

// ===== sv/xoshiro256pp_generator.sv =====
// Next transaction: result in the output register in the cycle after acceptance,
// one transaction per cycle while the output side keeps taking results.
// Seed transaction: per state word, one add, then two constant multiplies, each
// summing three partial products in a shared 32 by 32 multiplier; no result.
// Reset (synchronous, active low) clears all four state words, so results are zero
// until the first seed transaction.
module xoshiro256pp_generator import xo256_pkg::*; (
  input logic clk,
  input logic rst_n,
  xo256_in_if.sink    in_chan,
  xo256_out_if.source out_chan
);

  dp_cmd_t cmd;

  xo256_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_func   (in_chan.func),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .cmd       (cmd)
  );

  xo256_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .seed_value  (in_chan.seed_value),
    .random_word (out_chan.random_word)
  );

`ifndef SYNTHESIS
  // Seeding occupies the block.
  a_seed_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.func == FUNC_SEED) |=> !in_chan.ready)
    else $error("input accepted right after a seed transaction");

  // A result only appears after a next transaction was taken.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |->
      $past(in_chan.valid && in_chan.ready && in_chan.func == FUNC_NEXT))
    else $error("result appeared without a next transaction");

  // A stalled result must block new input.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |-> !in_chan.ready)
    else $error("input accepted while a result is stalled");
`endif

endmodule
